// ===== rtl/assert_macros.svh =====
// assertion macros shared by the reservation conflict table
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TRCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define TRCT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/trct_pkg.sv =====
// shared types and constants of the reservation conflict table
// no dependencies
package trct_pkg;

    localparam int ENTRIES_DEF    = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int TX_ID_BITS_DEF = 16;
    localparam int BATCH_BITS_DEF = 16;

    localparam logic [1:0] FUNC_RES_READ  = 2'd0;
    localparam logic [1:0] FUNC_RES_WRITE = 2'd1;
    localparam logic [1:0] FUNC_CHK_READ  = 2'd2;
    localparam logic [1:0] FUNC_CHK_WRITE = 2'd3;

    typedef enum logic [1:0] {
        OUTC_HIT  = 2'd0,
        OUTC_FREE = 2'd1,
        OUTC_FULL = 2'd2
    } outcome_t;

    typedef struct packed {
        logic     clear;
        logic     latch;
        logic     look;
        logic     advance;
        logic     finish;
        outcome_t outcome;
    } cmd_t;

    typedef struct packed {
        logic used;
        logic key_match;
        logic probe_last;
        logic clr_last;
    } status_t;

endpackage

// ===== rtl/trct_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module trct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/trct_ctrl.sv =====
// sequencer of the reservation conflict table: clear pass, probe, finish
// depends on trct_pkg
module trct_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  trct_pkg::status_t status,
    output trct_pkg::cmd_t    cmd,
    output logic             busy
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    trct_pkg::outcome_t  outcome_reg, outcome_next;
    logic                busy_reg, busy_next;

    always_comb
    begin
        state_next   = state_reg;
        outcome_next = outcome_reg;
        busy_next    = busy_reg;
        cmd          = '0;
        cmd.outcome  = outcome_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_LOOK;
                    busy_next  = 1'b1;
                end
            end
            ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.used && status.key_match)
                begin
                    outcome_next = trct_pkg::OUTC_HIT;
                    state_next   = ST_DONE;
                end
                else if (!status.used)
                begin
                    outcome_next = trct_pkg::OUTC_FREE;
                    state_next   = ST_DONE;
                end
                else if (status.probe_last)
                begin
                    outcome_next = trct_pkg::OUTC_FULL;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            outcome_reg <= trct_pkg::OUTC_HIT;
            busy_reg    <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            outcome_reg <= outcome_next;
            busy_reg    <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/trct_dp.sv =====
// datapath of the reservation conflict table: entry ram, probe pointer,
// claim and conflict logic, result registers; depends on trct_pkg, trct_ram
module trct_dp #(
    parameter int ENTRIES    = trct_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = trct_pkg::KEY_BITS_DEF,
    parameter int TX_ID_BITS = trct_pkg::TX_ID_BITS_DEF,
    parameter int BATCH_BITS = trct_pkg::BATCH_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  trct_pkg::cmd_t        cmd,
    output trct_pkg::status_t     status,
    input  logic                  cfg_valid,
    input  logic                  cfg_data,
    input  logic [1:0]            func,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [TX_ID_BITS-1:0] tx_id,
    input  logic [BATCH_BITS-1:0] batch_num,
    input  logic                  last_key,
    output logic                  result_valid,
    output logic                  raw_found,
    output logic                  war_found,
    output logic                  waw_found,
    output logic                  conflict,
    output logic                  verify_done,
    output logic                  table_full
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WORD_W = 1 + KEY_BITS + 2 * (1 + BATCH_BITS + TX_ID_BITS);

    // item registers
    logic [1:0]            func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [TX_ID_BITS-1:0] tx_reg;
    logic [BATCH_BITS-1:0] batch_reg;
    logic                  last_reg;

    logic [IDX_W-1:0] probe_idx_reg, probe_cnt_reg, clr_idx_reg;
    logic [IDX_W-1:0] hash;
    logic [IDX_W:0]   hash_wide;

    logic raw_seen_reg, war_seen_reg, waw_seen_reg, reorder_reg;
    logic result_valid_reg, raw_reg, war_reg, waw_reg;
    logic conflict_reg, done_reg, full_reg;

    // entry word fields
    logic [WORD_W-1:0]     rdata, wdata, upd_word;
    logic                  r_used, r_rp, r_wp;
    logic [KEY_BITS-1:0]   r_key;
    logic [BATCH_BITS-1:0] r_rb, r_wb;
    logic [TX_ID_BITS-1:0] r_rt, r_wt;
    logic                  b_rp, b_wp, take_r, take_w;
    logic                  we, is_reserve, hit, other_r, other_w;
    logic                  raw_now, war_now, waw_now, raw_acc, war_acc, waw_acc;

    assign {r_used, r_key, r_rp, r_rb, r_rt, r_wp, r_wb, r_wt} = rdata;

    // home slot: low key bits folded into the table range
    assign hash_wide = {1'b0, IDX_W'(key)};
    assign hash = (hash_wide >= (IDX_W+1)'(ENTRIES)) ?
                  IDX_W'(hash_wide - (IDX_W+1)'(ENTRIES)) : IDX_W'(hash_wide);

    assign status.used       = r_used;
    assign status.key_match  = (r_key == key_reg);
    assign status.probe_last = (probe_cnt_reg == IDX_W'(ENTRIES - 1));
    assign status.clr_last   = (clr_idx_reg == IDX_W'(ENTRIES - 1));

    assign is_reserve = (func_reg == trct_pkg::FUNC_RES_READ) ||
                        (func_reg == trct_pkg::FUNC_RES_WRITE);
    assign hit = (cmd.outcome == trct_pkg::OUTC_HIT);

    // a fresh entry starts with both slots empty
    assign b_rp = hit ? r_rp : 1'b0;
    assign b_wp = hit ? r_wp : 1'b0;

    assign take_r = !b_rp || (r_rb != batch_reg) || (r_rt > tx_reg);
    assign take_w = !b_wp || (r_wb != batch_reg) || (r_wt > tx_reg);

    always_comb
    begin
        upd_word = {1'b1, key_reg, b_rp, r_rb, r_rt, b_wp, r_wb, r_wt};
        if (func_reg == trct_pkg::FUNC_RES_READ)
        begin
            if (take_r)
            begin
                upd_word = {1'b1, key_reg, 1'b1, batch_reg, tx_reg, b_wp, r_wb, r_wt};
            end
        end
        else if (take_w)
        begin
            upd_word = {1'b1, key_reg, b_rp, r_rb, r_rt, 1'b1, batch_reg, tx_reg};
        end
    end

    assign other_r = r_rp && (r_rb == batch_reg) && (r_rt != tx_reg);
    assign other_w = r_wp && (r_wb == batch_reg) && (r_wt != tx_reg);
    assign raw_now = hit && (func_reg == trct_pkg::FUNC_CHK_READ) && other_w;
    assign war_now = hit && (func_reg == trct_pkg::FUNC_CHK_WRITE) && other_r;
    assign waw_now = hit && (func_reg == trct_pkg::FUNC_CHK_WRITE) && other_w;
    assign raw_acc = raw_seen_reg | raw_now;
    assign war_acc = war_seen_reg | war_now;
    assign waw_acc = waw_seen_reg | waw_now;

    assign we = cmd.clear ||
                (cmd.finish && is_reserve && (cmd.outcome != trct_pkg::OUTC_FULL));
    assign wdata = cmd.clear ? '0 : upd_word;

    trct_ram #(
        .WIDTH(WORD_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(cmd.clear ? clr_idx_reg : probe_idx_reg),
        .wdata(wdata),
        .re   (cmd.look),
        .raddr(probe_idx_reg),
        .rdata(rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg  <= func;
            key_reg   <= key;
            tx_reg    <= tx_id;
            batch_reg <= batch_num;
            last_reg  <= last_key;
        end
        if (cmd.finish)
        begin
            raw_reg      <= raw_now;
            war_reg      <= war_now;
            waw_reg      <= waw_now;
            full_reg     <= is_reserve && (cmd.outcome == trct_pkg::OUTC_FULL);
            done_reg     <= !is_reserve && last_reg;
            conflict_reg <= !is_reserve && last_reg &&
                            (waw_acc || (reorder_reg ? (raw_acc && war_acc) : raw_acc));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_idx_reg    <= '0;
            probe_cnt_reg    <= '0;
            clr_idx_reg      <= '0;
            raw_seen_reg     <= 1'b0;
            war_seen_reg     <= 1'b0;
            waw_seen_reg     <= 1'b0;
            reorder_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.finish;
            if (cfg_valid)
            begin
                reorder_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.latch)
            begin
                probe_idx_reg <= hash;
                probe_cnt_reg <= '0;
            end
            else if (cmd.advance)
            begin
                probe_idx_reg <= (probe_idx_reg == IDX_W'(ENTRIES - 1)) ?
                                 '0 : probe_idx_reg + 1'b1;
                probe_cnt_reg <= probe_cnt_reg + 1'b1;
            end
            if (cmd.finish && !is_reserve)
            begin
                raw_seen_reg <= last_reg ? 1'b0 : raw_acc;
                war_seen_reg <= last_reg ? 1'b0 : war_acc;
                waw_seen_reg <= last_reg ? 1'b0 : waw_acc;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign raw_found    = raw_reg;
    assign war_found    = war_reg;
    assign waw_found    = waw_reg;
    assign conflict     = conflict_reg;
    assign verify_done  = done_reg;
    assign table_full   = full_reg;

endmodule

// ===== rtl/txn_reservation_conflict_table_unit.sv =====
// top level of the transaction reservation conflict table
// depends on trct_pkg, trct_ctrl, trct_dp, trct_ram and assert_macros.svh

// reservation conflict table. an item is taken when start is high and busy is
// low; its single result appears on the cycle busy drops again, for exactly
// one cycle with result_valid high, and must be captured then since the
// receiver cannot stall. keys live in an open-addressed table (home slot from
// the low key bits, linear probe). an item keeps busy high until its result,
// and every extra probe step adds a look and a compare state, so no new item
// is taken while one is in flight; a full table walks every slot. the single
// ram port pair (one read, one write) bounds the probe walk: every probe is one
// registered read. after reset a clearing pass writes every entry to zero
// with busy high; configuration writes are taken at any time and cfg_ready
// stays high.
module txn_reservation_conflict_table_unit #(
    parameter int ENTRIES    = trct_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = trct_pkg::KEY_BITS_DEF,
    parameter int TX_ID_BITS = trct_pkg::TX_ID_BITS_DEF,
    parameter int BATCH_BITS = trct_pkg::BATCH_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // command side
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            func,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [TX_ID_BITS-1:0] tx_id,
    input  logic [BATCH_BITS-1:0] batch_num,
    input  logic                  last_key,
    // configuration transfer: reordering_enabled
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    // result side
    output logic                  result_valid,
    output logic                  raw_found,
    output logic                  war_found,
    output logic                  waw_found,
    output logic                  conflict,
    output logic                  verify_done,
    output logic                  table_full
);

`include "assert_macros.svh"

    trct_pkg::cmd_t    cmd;
    trct_pkg::status_t status;

    // register is a plain flop, always ready
    assign cfg_ready = 1'b1;

    // sequencer: clear pass, home probe, walk, finish
    trct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy)
    );

    // table ram plus claim and conflict evaluation
    trct_dp #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .TX_ID_BITS(TX_ID_BITS),
        .BATCH_BITS(BATCH_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid & cfg_ready),
        .cfg_data    (cfg_data),
        .func        (func),
        .key         (key),
        .tx_id       (tx_id),
        .batch_num   (batch_num),
        .last_key    (last_key),
        .result_valid(result_valid),
        .raw_found   (raw_found),
        .war_found   (war_found),
        .waw_found   (waw_found),
        .conflict    (conflict),
        .verify_done (verify_done),
        .table_full  (table_full)
    );

    // an accepted command keeps the block busy on the next cycle
    `TRCT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accept did not raise busy")
    // a result only follows a busy cycle
    `TRCT_ASSERT(a_result_after_busy, result_valid |-> $past(busy), "result without work")
    // a conflict decision only comes with verify_done
    `TRCT_NEVER(a_conflict_done, result_valid && conflict && !verify_done, "stray conflict")
    // a full-table reserve never reports check findings
    `TRCT_NEVER(a_full_no_find, result_valid && table_full && (raw_found || war_found), "mixed result")

endmodule
